FILE: src/i2cms_pkg.sv
// Shared types, codes and sequence tables for the I2C master sequencer.
// No dependencies; used by i2cms_core and i2c_master_sequencer.
package i2cms_pkg;

    // Commands
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_RD_ACK    = 3'd4;
    localparam logic [2:0] CMD_RD_NACK   = 3'd5;
    localparam logic [2:0] CMD_REG_WRITE = 3'd6;
    localparam logic [2:0] CMD_REG_READ  = 3'd7;

    // Segment kinds
    localparam logic [2:0] K_START     = 3'd0;
    localparam logic [2:0] K_STOP      = 3'd1;
    localparam logic [2:0] K_WRITE     = 3'd2;
    localparam logic [2:0] K_READ_ACK  = 3'd3;
    localparam logic [2:0] K_READ_NACK = 3'd4;

    // Byte sources for write segments
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_DEV  = 2'd1;
    localparam logic [1:0] SRC_REG  = 2'd2;
    localparam logic [1:0] SRC_DEV1 = 2'd3;

    // Sequence steps
    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_START      = 5'd1;
    localparam logic [4:0] ST_STOP       = 5'd2;
    localparam logic [4:0] ST_WRITE      = 5'd3;
    localparam logic [4:0] ST_RD_ACK     = 5'd4;
    localparam logic [4:0] ST_RD_NACK    = 5'd5;
    localparam logic [4:0] ST_RW_START   = 5'd6;
    localparam logic [4:0] ST_RW_DEV     = 5'd7;
    localparam logic [4:0] ST_RW_REG     = 5'd8;
    localparam logic [4:0] ST_RW_DATA    = 5'd9;
    localparam logic [4:0] ST_RW_STOP    = 5'd10;
    localparam logic [4:0] ST_RR_START   = 5'd11;
    localparam logic [4:0] ST_RR_DEV     = 5'd12;
    localparam logic [4:0] ST_RR_REG     = 5'd13;
    localparam logic [4:0] ST_RR_RESTART = 5'd14;
    localparam logic [4:0] ST_RR_DEV1    = 5'd15;
    localparam logic [4:0] ST_RR_READ    = 5'd16;
    localparam logic [4:0] ST_RR_STOP    = 5'd17;
    localparam logic [4:0] ST_COUNT      = 5'd18;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] device_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack_seen;
    } t_out_item;

    typedef struct packed {
        logic scl;
        logic sda;
    } t_lines;

    function automatic logic [2:0] step_kind(input logic [4:0] step);
        case (step)
            ST_STOP, ST_RW_STOP, ST_RR_STOP:              return K_STOP;
            ST_WRITE, ST_RW_DEV, ST_RW_REG, ST_RW_DATA,
            ST_RR_DEV, ST_RR_REG, ST_RR_DEV1:             return K_WRITE;
            ST_RD_ACK:                                    return K_READ_ACK;
            ST_RD_NACK, ST_RR_READ:                       return K_READ_NACK;
            default:                                      return K_START;
        endcase
    endfunction

    function automatic logic [1:0] step_src(input logic [4:0] step);
        case (step)
            ST_RW_DEV, ST_RR_DEV: return SRC_DEV;
            ST_RW_REG, ST_RR_REG: return SRC_REG;
            ST_RR_DEV1:           return SRC_DEV1;
            default:              return SRC_DATA;
        endcase
    endfunction

    function automatic logic [4:0] step_next(input logic [4:0] step);
        case (step)
            ST_RW_START:   return ST_RW_DEV;
            ST_RW_DEV:     return ST_RW_REG;
            ST_RW_REG:     return ST_RW_DATA;
            ST_RW_DATA:    return ST_RW_STOP;
            ST_RR_START:   return ST_RR_DEV;
            ST_RR_DEV:     return ST_RR_REG;
            ST_RR_REG:     return ST_RR_RESTART;
            ST_RR_RESTART: return ST_RR_DEV1;
            ST_RR_DEV1:    return ST_RR_READ;
            ST_RR_READ:    return ST_RR_STOP;
            default:       return ST_IDLE;
        endcase
    endfunction

    function automatic logic [4:0] cmd_first(input logic [2:0] cmd);
        case (cmd)
            CMD_START:     return ST_START;
            CMD_STOP:      return ST_STOP;
            CMD_WRITE:     return ST_WRITE;
            CMD_RD_ACK:    return ST_RD_ACK;
            CMD_RD_NACK:   return ST_RD_NACK;
            CMD_REG_WRITE: return ST_RW_START;
            CMD_REG_READ:  return ST_RR_START;
            default:       return ST_IDLE;
        endcase
    endfunction

    // Line levels driven at the start of a phase.
    function automatic t_lines apply_phase(
        input logic [2:0] kind,
        input logic [1:0] phase,
        input logic [3:0] bit_idx,
        input logic [7:0] shift,
        input t_lines     cur
    );
        t_lines l;
        l = cur;
        case (kind)
            K_START: begin
                case (phase)
                    2'd0:    l.sda = 1'b1;
                    2'd1:    l.scl = 1'b1;
                    2'd2:    l.sda = 1'b0;
                    default: l.scl = 1'b0;
                endcase
            end
            K_STOP: begin
                case (phase)
                    2'd0:    l.scl = 1'b0;
                    2'd1:    l.sda = 1'b0;
                    2'd2:    l.scl = 1'b1;
                    default: l.sda = 1'b1;
                endcase
            end
            K_WRITE: begin
                if (phase == 2'd0) begin
                    l.sda = (bit_idx < BITS_PER_BYTE) ? shift[7] : 1'b1;
                end else if (phase == 2'd1) begin
                    l.scl = 1'b1;
                end else begin
                    l.scl = 1'b0;
                end
            end
            default: begin
                // read segments: release, 8 data clocks, then ack/nack clock
                if (bit_idx == 4'd0) begin
                    l.sda = 1'b1;
                end else if (bit_idx <= BITS_PER_BYTE) begin
                    l.scl = (phase != 2'd0);
                end else begin
                    case (phase)
                        2'd0:    l.scl = 1'b0;
                        2'd1:    l.sda = (kind != K_READ_ACK);
                        2'd2:    l.scl = 1'b1;
                        default: l.scl = 1'b0;
                    endcase
                end
            end
        endcase
        return l;
    endfunction

endpackage

FILE: src/i2c_master_sequencer.sv
// I2C master sequencer top level: input register, tick logic, result register.
// A result is registered: the input register loads on the transfer edge, the
// result register when the held tick advances, which an output stall can delay.
// Throughput: one transfer per cycle in both directions while i_out_stall is low.
// Reset (synchronous, i_rst_n low): idle, SCL and SDA released, phase_ticks = 2.
// Depends on i2cms_pkg and i2cms_core.
module i2c_master_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  i2cms_pkg::t_in_item   i_in_item,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cms_pkg::t_out_item  o_out_item,
    // phase_ticks register
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data
);

    // Input register: holds one tick's command and SDA sample.
    logic                 r_in_valid;
    i2cms_pkg::t_in_item  r_in_item;

    // Result register: holds one tick's line levels and status.
    logic                 r_out_valid;
    i2cms_pkg::t_out_item r_out_item;

    i2cms_pkg::t_out_item core_res;
    logic                 in_xfer;
    logic                 advance;

    // The held tick moves into the result register whenever that register is
    // empty or its current transfer completes this cycle. The sequencer state
    // advances on exactly the same edge, so one tick is processed per item.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    i2cms_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_item     (r_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    // Payload holds while stalled; loads only on a tick that advances.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: src/i2cms_core.sv
// Sequencer state and one-tick next-state logic for the I2C master.
// Depends on i2cms_pkg.
module i2cms_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  i2cms_pkg::t_in_item   i_item,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data,
    output i2cms_pkg::t_out_item  o_res
);

    logic [7:0] r_ticks;
    logic [4:0] r_step,  n_step;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_hold,  n_hold;
    logic [3:0] r_bit,   n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_dev,   n_dev;
    logic [7:0] r_reg,   n_reg;
    logic [7:0] r_data,  n_data;
    logic [7:0] r_rx,    n_rx;
    logic       r_nack,  n_nack;
    i2cms_pkg::t_lines r_lines, n_lines;

    logic [4:0] step_cur;
    logic [4:0] step_new;
    logic [2:0] kind;
    logic [7:0] hold_dec;
    logic [7:0] reload;
    logic       seg_done;
    logic       done;

    assign reload = (r_ticks == 8'd0) ? 8'd1 : r_ticks;

    always_comb begin
        n_step   = r_step;
        n_phase  = r_phase;
        n_hold   = r_hold;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_dev    = r_dev;
        n_reg    = r_reg;
        n_data   = r_data;
        n_rx     = r_rx;
        n_nack   = r_nack;
        n_lines  = r_lines;
        seg_done = 1'b0;
        done     = 1'b0;
        step_new = i2cms_pkg::ST_IDLE;
        hold_dec = (r_hold != 8'd0) ? r_hold - 8'd1 : r_hold;

        step_cur = (r_step >= i2cms_pkg::ST_COUNT) ? i2cms_pkg::ST_IDLE : r_step;
        kind     = i2cms_pkg::step_kind(step_cur);
        n_step   = step_cur;

        if (step_cur != i2cms_pkg::ST_IDLE) begin
            n_hold = hold_dec;
            if (hold_dec == 8'd0) begin
                // end of the current phase
                if (kind inside {i2cms_pkg::K_START, i2cms_pkg::K_STOP}) begin
                    if (r_phase == 2'd3) seg_done = 1'b1;
                    else n_phase = r_phase + 2'd1;
                end else if (kind == i2cms_pkg::K_WRITE) begin
                    if (r_phase == 2'd1 && r_bit == i2cms_pkg::BITS_PER_BYTE) begin
                        n_nack = i_item.sda_in;
                    end
                    if (r_phase >= 2'd2) begin
                        if (r_bit >= i2cms_pkg::BITS_PER_BYTE) begin
                            seg_done = 1'b1;
                        end else begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 4'd1;
                            n_phase = 2'd0;
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end else begin
                    if (r_bit == 4'd0) begin
                        n_bit   = 4'd1;
                        n_phase = 2'd0;
                    end else if (r_bit <= i2cms_pkg::BITS_PER_BYTE) begin
                        if (r_phase == 2'd1) begin
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_bit   = r_bit + 4'd1;
                            n_phase = 2'd0;
                        end else begin
                            n_phase = 2'd1;
                        end
                    end else begin
                        if (r_phase == 2'd3) begin
                            n_rx     = r_shift;
                            seg_done = 1'b1;
                        end else begin
                            n_phase = r_phase + 2'd1;
                        end
                    end
                end

                if (seg_done) begin
                    step_new = i2cms_pkg::step_next(step_cur);
                    if (step_new == i2cms_pkg::ST_IDLE) begin
                        n_step  = i2cms_pkg::ST_IDLE;
                        n_phase = 2'd0;
                        n_bit   = 4'd0;
                        done    = 1'b1;
                    end
                end else begin
                    n_lines = i2cms_pkg::apply_phase(kind, n_phase, n_bit, n_shift,
                                                     r_lines);
                    n_hold  = reload;
                end
            end
        end else if (i_item.command != i2cms_pkg::CMD_NONE) begin
            n_dev    = i_item.device_addr;
            n_reg    = i_item.reg_addr;
            n_data   = i_item.wr_byte;
            step_new = i2cms_pkg::cmd_first(i_item.command);
        end

        // enter a new segment
        if (step_new != i2cms_pkg::ST_IDLE) begin
            n_step  = step_new;
            n_phase = 2'd0;
            n_bit   = 4'd0;
            n_shift = 8'd0;
            if (i2cms_pkg::step_kind(step_new) == i2cms_pkg::K_WRITE) begin
                case (i2cms_pkg::step_src(step_new))
                    i2cms_pkg::SRC_DEV:  n_shift = n_dev;
                    i2cms_pkg::SRC_REG:  n_shift = n_reg;
                    i2cms_pkg::SRC_DEV1: n_shift = n_dev + 8'd1;
                    default:             n_shift = n_data;
                endcase
            end
            n_lines = i2cms_pkg::apply_phase(i2cms_pkg::step_kind(step_new), 2'd0, 4'd0,
                                             n_shift, r_lines);
            n_hold  = reload;
        end
    end

    always_comb begin
        o_res.scl_level   = n_lines.scl;
        o_res.sda_release = n_lines.sda;
        o_res.busy_res    = (n_step != i2cms_pkg::ST_IDLE);
        o_res.done_res    = done;
        o_res.read_data   = n_rx;
        o_res.nack_seen   = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= i2cms_pkg::PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= i2cms_pkg::ST_IDLE;
            r_phase     <= 2'd0;
            r_hold      <= 8'd0;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_dev       <= 8'd0;
            r_reg       <= 8'd0;
            r_data      <= 8'd0;
            r_rx        <= 8'd0;
            r_nack      <= 1'b0;
            r_lines.scl <= 1'b1;
            r_lines.sda <= 1'b1;
        end else if (i_en) begin
            r_step  <= n_step;
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_data  <= n_data;
            r_rx    <= n_rx;
            r_nack  <= n_nack;
            r_lines <= n_lines;
        end
    end

endmodule
